// ===== design/fkg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkg_pkg: shared types and constants of the fractional knapsack block
// item and result formats, store sizing, fixed point widths, shared unit ports
// ----------------------------------------------------------------------------
package fkg_pkg;

    // store sizing
    localparam int MAX_ITEMS = 16;
    localparam int SLOT_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // field widths
    localparam int VAL_W   = 16;
    localparam int CAP_W   = 20;
    localparam int IDX_W   = 4;
    localparam int FRAC_W  = 16;
    localparam int FRACQ_W = FRAC_W + 1;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = 37;
    localparam int TOT_W   = 36;
    localparam int PW_W    = 2 * VAL_W;

    localparam int DIV_CNT_W = $clog2(FRAC_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_W - 1);

    // one whole item in q1.16
    localparam logic [FRACQ_W-1:0] Q16_ONE = FRACQ_W'(1) << FRAC_W;

    typedef struct packed {
        logic [VAL_W-1:0] profit;
        logic [VAL_W-1:0] weight;
        logic             end_of_items;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   original_index;
        logic [VAL_W-1:0]   item_weight;
        logic [VAL_W-1:0]   item_profit;
        logic [FRACQ_W-1:0] fraction;
        logic [TOT_W-1:0]   total_profit;
        logic               overflow;
        logic               final_result;
    } out_item_t;

    // one entry of the item store
    typedef struct packed {
        logic [VAL_W-1:0] profit;
        logic [VAL_W-1:0] weight;
    } item_pw_t;

    // shared arithmetic unit operands and results
    typedef struct packed {
        logic [VAL_W-1:0] mul_a;
        logic [VAL_W-1:0] mul_b;
        logic [CAP_W-1:0] sub_a;
        logic [VAL_W-1:0] sub_b;
    } alu_in_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic [CAP_W-1:0]  diff;
        logic              borrow;
    } alu_out_t;

endpackage

// ===== design/fkg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkg_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fkg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fkg_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkg_alu: shared arithmetic unit
// one 16x16 multiplier and one capacity-wide subtractor with borrow
// ----------------------------------------------------------------------------
module fkg_alu (
    input  fkg_pkg::alu_in_t  alu_in,
    output fkg_pkg::alu_out_t alu_out
);
    import fkg_pkg::*;

    logic [CAP_W:0] diff_full;

    // ratio cross products and fraction times profit
    assign alu_out.prod = PROD_W'(alu_in.mul_a) * PROD_W'(alu_in.mul_b);

    // capacity check and restoring divide step
    assign diff_full      = (CAP_W + 1)'(alu_in.sub_a) - (CAP_W + 1)'(alu_in.sub_b);
    assign alu_out.diff   = diff_full[CAP_W-1:0];
    assign alu_out.borrow = diff_full[CAP_W];

endmodule

// ===== design/fractional_knapsack_greedy.sv =====
`timescale 1ns / 1ps
// insert: a non-final item makes c ratio compares, c = items it moves past
// (plus one more when it stops short of the head), each through two multiplies
// emit: a whole item or zero-weight item with nothing left goes straight to output, else
// a 16-step serial divide and a multiply come first; an output stall holds the result
// throughput: one item at a time, all steps run through one shared multiplier/subtractor
// reset: asynchronous, active low; clears set, capacity, sequencer and output valid
// ----------------------------------------------------------------------------
// fractional_knapsack_greedy: greedy fractional knapsack over a stored set
// keeps items sorted by profit per weight as they arrive (insertion by
// cross-multiplied compare), then fills the capacity and emits one result
// per stored item in sorted order with q16 fraction and running profit
// item store needs no clearing pass, only entries of the current set are read
// ----------------------------------------------------------------------------
module fractional_knapsack_greedy (
    input  logic                       clk,
    input  logic                       rst_n,
    // item requests
    input  logic                       in_valid,
    output logic                       in_stall,
    input  fkg_pkg::in_item_t          in_data,
    // result requests
    output logic                       out_valid,
    input  logic                       out_stall,
    output fkg_pkg::out_item_t         out_data,
    // capacity register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fkg_pkg::CAP_W-1:0]  cfg_data
);
    import fkg_pkg::*;

    // sequencer states: insertion of a new item, then greedy emit
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_ORD_RD = 14'b00000000000010,
        S_PW_RD  = 14'b00000000000100,
        S_MUL1   = 14'b00000000001000,
        S_MUL2   = 14'b00000000010000,
        S_CMP    = 14'b00000000100000,
        S_PLACE  = 14'b00000001000000,
        S_E_ORD  = 14'b00000010000000,
        S_E_PW   = 14'b00000100000000,
        S_E_DEC  = 14'b00001000000000,
        S_E_DIV  = 14'b00010000000000,
        S_E_MUL  = 14'b00100000000000,
        S_E_ACC  = 14'b01000000000000,
        S_E_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // set control
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic              last_reg, last_next;
    logic [CAP_W-1:0]  cap_reg;

    // insertion and emit positions
    logic [SLOT_W-1:0] j_reg, j_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [SLOT_W-1:0] s_reg, s_next;

    // operands and products
    logic [VAL_W-1:0]  p_cur_reg, p_cur_next;
    logic [VAL_W-1:0]  w_cur_reg, w_cur_next;
    logic [VAL_W-1:0]  p_s_reg, p_s_next;
    logic [VAL_W-1:0]  w_s_reg, w_s_next;
    logic [PROD_W-1:0] lhs_reg, lhs_next;
    logic [PROD_W-1:0] rhs_reg, rhs_next;

    // greedy fill state
    logic [CAP_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [FRAC_W-1:0] r_reg, r_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [FRACQ_W-1:0] frac_reg, frac_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    // memories
    logic              ord_we;
    logic [SLOT_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic              pw_we;
    logic [SLOT_W-1:0] pw_waddr, pw_raddr;
    item_pw_t          pw_wdata, pw_rd;
    logic [PW_W-1:0]   pw_rdata;

    alu_in_t           alu_in;
    alu_out_t          alu_out;

    logic              in_accept;
    logic              out_load;
    logic              last_result;

    // sorted order: slot numbers, best ratio first
    fkg_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_ITEMS)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    // item store: profit and weight by load slot
    fkg_ram #(
        .WIDTH (PW_W),
        .DEPTH (MAX_ITEMS)
    ) u_item_ram (
        .clk   (clk),
        .we    (pw_we),
        .waddr (pw_waddr),
        .wdata (pw_wdata),
        .raddr (pw_raddr),
        .rdata (pw_rdata)
    );

    assign pw_rd = item_pw_t'(pw_rdata);

    fkg_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    // handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // result register free or being drained this cycle
    assign out_load    = (state_reg == S_E_OUT) && (!out_valid_reg || !out_stall);
    assign last_result = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    // shared unit operand select
    always_comb
    begin
        alu_in.mul_a = p_cur_reg;
        alu_in.mul_b = pw_rd.weight;
        alu_in.sub_a = rem_reg;
        alu_in.sub_b = pw_rd.weight;
        unique case (state_reg)
            S_MUL2:
            begin
                // profit of stored item times weight of new item
                alu_in.mul_a = p_s_reg;
                alu_in.mul_b = w_cur_reg;
            end
            S_E_MUL:
            begin
                // partial fraction times profit
                alu_in.mul_a = quot_reg;
                alu_in.mul_b = p_s_reg;
            end
            S_E_DIV:
            begin
                // shifted remainder against weight
                alu_in.sub_a = CAP_W'({r_reg, 1'b0});
                alu_in.sub_b = w_s_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        p_cur_next     = p_cur_reg;
        w_cur_next     = w_cur_reg;
        p_s_next       = p_s_reg;
        w_s_next       = w_s_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        r_next         = r_reg;
        quot_next      = quot_reg;
        div_cnt_next   = div_cnt_reg;
        frac_next      = frac_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);

        ord_we    = 1'b0;
        ord_waddr = j_reg;
        ord_wdata = s_reg;
        ord_raddr = j_reg - SLOT_W'(1);
        pw_we     = 1'b0;
        pw_waddr  = count_reg[SLOT_W-1:0];
        pw_wdata  = '{profit: in_data.profit, weight: in_data.weight};
        pw_raddr  = ord_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    last_next = in_data.end_of_items;
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        // store and start insertion from the tail
                        pw_we      = 1'b1;
                        cur_next   = count_reg[SLOT_W-1:0];
                        j_next     = count_reg[SLOT_W-1:0];
                        p_cur_next = in_data.profit;
                        w_cur_next = in_data.weight;
                        count_next = count_reg + CNT_W'(1);
                        state_next = (count_reg == '0) ? S_PLACE : S_ORD_RD;
                    end
                    else
                    begin
                        // store full: drop the item, still start the fill when it is the last
                        dropped_next = 1'b1;
                        if (in_data.end_of_items)
                        begin
                            rem_next   = cap_reg;
                            sum_next   = '0;
                            k_next     = '0;
                            state_next = S_E_ORD;
                        end
                    end
                end
            end
            S_ORD_RD:
            begin
                state_next = S_PW_RD;
            end
            S_PW_RD:
            begin
                s_next     = ord_rdata;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                p_s_next   = pw_rd.profit;
                w_s_next   = pw_rd.weight;
                lhs_next   = alu_out.prod;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                rhs_next   = alu_out.prod;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // equal products: the newer item goes first
                if (lhs_reg >= rhs_reg)
                begin
                    ord_we     = 1'b1;
                    j_next     = j_reg - SLOT_W'(1);
                    state_next = (j_reg == SLOT_W'(1)) ? S_PLACE : S_ORD_RD;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                ord_we    = 1'b1;
                ord_wdata = cur_reg;
                if (last_reg)
                begin
                    rem_next   = cap_reg;
                    sum_next   = '0;
                    k_next     = '0;
                    state_next = S_E_ORD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_E_ORD:
            begin
                ord_raddr  = k_reg;
                state_next = S_E_PW;
            end
            S_E_PW:
            begin
                s_next     = ord_rdata;
                state_next = S_E_DEC;
            end
            S_E_DEC:
            begin
                p_s_next = pw_rd.profit;
                w_s_next = pw_rd.weight;
                if ((rem_reg != '0) && !alu_out.borrow)
                begin
                    // fits: take whole
                    frac_next  = Q16_ONE;
                    rem_next   = alu_out.diff;
                    sum_next   = sum_reg + SUM_W'({pw_rd.profit, {FRAC_W{1'b0}}});
                    state_next = S_E_OUT;
                end
                else if (pw_rd.weight != '0)
                begin
                    // remaining below weight: fraction by restoring divide
                    r_next       = rem_reg[FRAC_W-1:0];
                    quot_next    = '0;
                    div_cnt_next = '0;
                    state_next   = S_E_DIV;
                end
                else
                begin
                    frac_next  = '0;
                    state_next = S_E_OUT;
                end
            end
            S_E_DIV:
            begin
                if (!alu_out.borrow)
                begin
                    r_next    = alu_out.diff[FRAC_W-1:0];
                    quot_next = {quot_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    r_next    = {r_reg[FRAC_W-2:0], 1'b0};
                    quot_next = {quot_reg[FRAC_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_E_MUL;
                end
            end
            S_E_MUL:
            begin
                lhs_next   = alu_out.prod;
                state_next = S_E_ACC;
            end
            S_E_ACC:
            begin
                sum_next   = sum_reg + SUM_W'(lhs_reg);
                rem_next   = '0;
                frac_next  = FRACQ_W'(quot_reg);
                state_next = S_E_OUT;
            end
            S_E_OUT:
            begin
                if (out_load)
                begin
                    out_data_next.original_index = IDX_W'(s_reg);
                    out_data_next.item_weight    = w_s_reg;
                    out_data_next.item_profit    = p_s_reg;
                    out_data_next.fraction       = frac_reg;
                    out_data_next.total_profit   = sum_reg[TOT_W-1:0];
                    out_data_next.overflow       = dropped_reg;
                    out_data_next.final_result   = last_result;
                    if (last_result)
                    begin
                        // set done, fill state stays until the next set
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + SLOT_W'(1);
                        state_next = S_E_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            last_reg      <= 1'b0;
            cap_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            last_reg      <= last_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            div_cnt_reg   <= div_cnt_next;
            rem_reg       <= rem_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        s_reg        <= s_next;
        p_cur_reg    <= p_cur_next;
        w_cur_reg    <= w_cur_next;
        p_s_reg      <= p_s_next;
        w_s_reg      <= w_s_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        r_reg        <= r_next;
        quot_reg     <= quot_next;
        frac_reg     <= frac_next;
        out_data_reg <= out_data_next;
    end

    // divide remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_E_DIV) |-> (r_reg < w_s_reg))
        else $error("divide remainder not below weight");

    // anything short of a whole item leaves no capacity behind
    a_partial_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (frac_reg != Q16_ONE)) |-> (rem_reg == '0))
        else $error("capacity left after partial item");

    // insertion never reads in front of the head
    a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ORD_RD) |-> ((j_reg != '0) && (CNT_W'(j_reg) < count_reg)))
        else $error("insertion position out of range");

    // last result of a set returns the block to loading
    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_result) |=> ((state_reg == S_IDLE) && (count_reg == '0)))
        else $error("set not closed after last result");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for fractional_knapsack_greedy
// item sets go in through a queue-fed driver with random gaps; a predictor
// ranks each set by cross-multiplied profit per weight, fills the capacity
// greedily and queues the results it expects; a monitor checks every result
// field by field while the receiver stalls at random and once for a long spell
// ----------------------------------------------------------------------------
module tb;
    import fkg_pkg::*;

    // settle time before a capacity write: worst insertion of a non-final item
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_GAP       = 18;
    localparam int MAX_PRINTS    = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data = '0;

    fractional_knapsack_greedy uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // item requests waiting for the driver
    in_item_t  item_queue[$];
    // results the predictor has worked out, oldest first
    out_item_t expected_results[$];

    // predictor copy of the block state
    logic [CAP_W-1:0] cap_setting = '0;
    logic [VAL_W-1:0] slot_profit[MAX_ITEMS];
    logic [VAL_W-1:0] slot_weight[MAX_ITEMS];
    int               slot_count = 0;
    bit               set_dropped = 1'b0;

    // run bookkeeping
    int  error_count = 0;
    int  items_taken = 0;
    int  sets_done = 0;
    int  overfull_sets = 0;
    int  results_seen = 0;
    int  cap_writes = 0;
    bit  no_idle = 1'b0;
    int  hold_requests = 0;
    bit  in_fire = 1'b0;

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("error: %s", msg);
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, expected %0h",
                results_seen, name, got, want));
    endtask

    // slot a ranks ahead of slot b: larger cross product, later slot on a tie
    function automatic bit ranks_ahead(int a, int b);
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        lhs = PROD_W'(slot_profit[a]) * PROD_W'(slot_weight[b]);
        rhs = PROD_W'(slot_profit[b]) * PROD_W'(slot_weight[a]);
        if (lhs != rhs)
            return lhs > rhs;
        return a > b;
    endfunction

    // store one item; on the last of a set, rank and fill, queue the results
    task automatic predict_knapsack(in_item_t item);
        int               order[MAX_ITEMS];
        int               i, j, cur, s;
        logic [CAP_W-1:0] left;
        logic [SUM_W-1:0] acc;
        logic [TOT_W-1:0] num;
        logic [FRACQ_W-1:0] frac;
        out_item_t        res;
        items_taken++;
        if (slot_count < MAX_ITEMS)
        begin
            slot_profit[slot_count] = item.profit;
            slot_weight[slot_count] = item.weight;
            slot_count++;
        end
        else
            set_dropped = 1'b1;
        if (!item.end_of_items)
            return;

        // insertion from the back, same walk as items arriving one by one
        for (i = 0; i < slot_count; i++)
            order[i] = i;
        for (i = 1; i < slot_count; i++)
        begin
            cur = order[i];
            j = i;
            while (j > 0 && ranks_ahead(cur, order[j-1]))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end

        left = cap_setting;
        acc  = '0;
        for (i = 0; i < slot_count; i++)
        begin
            s = order[i];
            if (left != 0 && CAP_W'(slot_weight[s]) <= left)
            begin
                frac = Q16_ONE;
                left = left - CAP_W'(slot_weight[s]);
                acc  = acc + (SUM_W'(slot_profit[s]) << FRAC_W);
            end
            else if (slot_weight[s] != 0)
            begin
                num  = TOT_W'(left) << FRAC_W;
                frac = FRACQ_W'(num / TOT_W'(slot_weight[s]));
                acc  = acc + SUM_W'(frac) * SUM_W'(slot_profit[s]);
                left = '0;
            end
            else
                frac = '0;
            res.original_index = IDX_W'(s);
            res.item_weight    = slot_weight[s];
            res.item_profit    = slot_profit[s];
            res.fraction       = frac;
            res.total_profit   = acc[TOT_W-1:0];
            res.overflow       = set_dropped;
            res.final_result   = (i == slot_count - 1);
            expected_results.push_back(res);
        end
        sets_done++;
        if (set_dropped)
            overfull_sets++;
        slot_count  = 0;
        set_dropped = 1'b0;
    endtask

    // input side: sample acceptance, feed the predictor, check results
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                predict_knapsack(in_data);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_error($sformatf("result %0d arrived with nothing expected",
                        results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("original_index", 64'(out_data.original_index),
                        64'(want.original_index));
                    compare_field("item_weight", 64'(out_data.item_weight),
                        64'(want.item_weight));
                    compare_field("item_profit", 64'(out_data.item_profit),
                        64'(want.item_profit));
                    compare_field("fraction", 64'(out_data.fraction), 64'(want.fraction));
                    compare_field("total_profit", 64'(out_data.total_profit),
                        64'(want.total_profit));
                    compare_field("overflow", 64'(out_data.overflow), 64'(want.overflow));
                    compare_field("final_result", 64'(out_data.final_result),
                        64'(want.final_result));
                end
            end
        end
    end

    // driver: one request at a time from the queue, random gap after each
    int drv_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_fire)
                ;   // request still pending, payload held
            else if (drv_gap > 0)
            begin
                drv_gap  <= drv_gap - 1;
                in_valid <= 1'b0;
            end
            else if (item_queue.size() > 0)
            begin
                in_data  <= item_queue.pop_front();
                in_valid <= 1'b1;
                drv_gap  <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: fresh random stall after each result taken
    int rx_left = 0;
    int rx_seen = 0;
    bit rx_stall = 1'b0;
    always @(negedge clk)
    begin
        int left;
        left = rx_left;
        if (rx_seen != results_seen)
            left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        else if (left > 0)
            left--;
        rx_seen  <= results_seen;
        rx_left  <= left;
        rx_stall <= (left > 0);
    end

    // long receiver hold-off, so results back up and the block stalls its input
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    assign out_stall = rx_stall | (hold_left > 0);

    task automatic push_item(logic [VAL_W-1:0] p, logic [VAL_W-1:0] w, bit last);
        in_item_t it;
        it.profit       = p;
        it.weight       = w;
        it.end_of_items = last;
        item_queue.push_back(it);
    endtask

    // capacity write, only while the block is idle
    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_setting = value;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mixed set: weight scale per set so both whole and partial items appear
    task automatic queue_random_set(output int n);
        int               i, k, hi;
        logic [VAL_W-1:0] p, w;
        n  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        k  = $urandom_range(1, 16);
        hi = (1 << k) - 1;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       p = '0;
                1:       p = '1;
                default: p = VAL_W'($urandom_range(0, 65535));
            endcase
            // zero weight now and then, ranks ahead of everything with profit
            w = ($urandom_range(0, 29) == 0) ? '0 : VAL_W'($urandom_range(1, hi));
            push_item(p, w, i == n - 1);
        end
    endtask

    // wait until every request is in and every result is out, then settle
    task automatic wait_drained();
        while (item_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int               ph, n, ph_items, i;
        logic [CAP_W-1:0] cap;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_capacity(CAP_W'(1000));

        // single heavy item, taken in part
        push_item('1, '1, 1'b1);
        // zero profit, max ratio, equal ratios (later first), all taken whole
        push_item(16'd0, 16'd1, 1'b0);
        push_item('1, 16'd1, 1'b0);
        push_item(16'd100, 16'd10, 1'b0);
        push_item(16'd200, 16'd20, 1'b0);
        push_item(16'd50, 16'd500, 1'b1);
        // zero weights, with and without profit
        push_item(16'd10, 16'd0, 1'b0);
        push_item(16'd0, 16'd0, 1'b0);
        push_item(16'd300, 16'd400, 1'b1);
        // store full, the final item itself is dropped
        for (i = 0; i < MAX_ITEMS + 1; i++)
            push_item(VAL_W'(i * 4000), VAL_W'(1000 + i * 3000), i == MAX_ITEMS);
        wait_drained();

        for (ph = 0; ph < 6; ph++)
        begin
            no_idle = (ph == 1 || ph == 4);
            case (ph)
                0:       cap = '0;
                1:       cap = '1;
                2:       cap = CAP_W'(1);
                3:       cap = CAP_W'($urandom_range(0, 65535));
                4:       cap = CAP_W'($urandom_range(0, 1048575));
                default: cap = CAP_W'($urandom_range(0, 300000));
            endcase
            write_capacity(cap);
            if (ph == 4)
                hold_requests++;
            ph_items = 0;
            while (ph_items < 16)
            begin
                queue_random_set(n);
                ph_items += n;
            end
            wait_drained();
        end

        $display("covered %0d items in %0d sets (%0d overfull), %0d results checked",
            items_taken, sets_done, overfull_sets, results_seen);
        $display("%0d capacity writes incl. zero and full scale, one %0d-cycle hold-off",
            cap_writes, HOLD_CYCLES);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== fractional_knapsack_greedy.f =====
design/fkg_pkg.sv
design/fkg_ram.sv
design/fkg_alu.sv
design/fractional_knapsack_greedy.sv
tb/sv/tb.sv
